// ===== rtl/grmt_pkg.sv =====
// shared constants, types and helpers for the grid range maximum tree
package grmt_pkg;

  localparam int MAX_SIDE       = 256;
  localparam int VALUE_BITS     = 32;
  localparam int SIDE_BITS      = 9;
  localparam int NODE_BITS      = $clog2(MAX_SIDE) + 1;
  localparam int ADDR_BITS      = 2 * NODE_BITS;
  localparam int MEM_DEPTH      = 1 << ADDR_BITS;
  localparam int STACK_DEPTH    = NODE_BITS;
  localparam int STACK_IDX_BITS = $clog2(STACK_DEPTH);
  localparam int STACK_PTR_BITS = $clog2(STACK_DEPTH + 1);
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COLS = 1'b1;
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [SIDE_BITS-1:0]         side_t;
  typedef logic [NODE_BITS-1:0]         node_t;
  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [ADDR_BITS-1:0]         addr_t;

  typedef struct packed {
    logic   command;
    side_t  cell_row;
    side_t  cell_col;
    value_t cell_value;
    side_t  row_low;
    side_t  col_low;
    side_t  row_high;
    side_t  col_high;
  } item_t;

  typedef struct packed {
    node_t node;
    side_t lo;
    side_t hi;
  } frame_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_PATH, OP_WR_RDA, OP_WR_RDB, OP_WR_WRITE,
    OP_OVISIT, OP_IVISIT, OP_IACC, OP_OPOP, OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic clear_last;
    logic is_query;
    logic write_ok;
    logic query_bad;
    logic path_done;
    logic write_last;
    logic out_covered;
    logic in_covered;
    logic out_empty;
    logic in_empty;
  } dp_status_t;

  function automatic value_t vmax(value_t a, value_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic side_t clamp_side(side_t v);
    side_t r;
    if (v == '0) r = side_t'(1);
    else if (v > side_t'(MAX_SIDE)) r = side_t'(MAX_SIDE);
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/grmt_in_if.sv =====
// command channel carrying write and query words
interface grmt_in_if import grmt_pkg::*;;
  logic   valid;
  logic   ready;
  logic   command;
  side_t  cell_row;
  side_t  cell_col;
  value_t cell_value;
  side_t  row_low;
  side_t  col_low;
  side_t  row_high;
  side_t  col_high;

  modport source (output valid, command, cell_row, cell_col, cell_value, row_low,
                  col_low, row_high, col_high, input ready);
  modport sink (input valid, command, cell_row, cell_col, cell_value, row_low,
                col_low, row_high, col_high, output ready);
endinterface

// ===== rtl/grmt_out_if.sv =====
// result channel carrying query answers
interface grmt_out_if import grmt_pkg::*;;
  logic   valid;
  logic   ready;
  value_t max_value;
  logic   range_error;

  modport source (output valid, max_value, range_error, input ready);
  modport sink (input valid, max_value, range_error, output ready);
endinterface

// ===== rtl/grmt_cfg_if.sv =====
// register write channel
interface grmt_cfg_if import grmt_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  side_t                   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/grmt_ram.sv =====
// generic single write port ram with registered read
module grmt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/grmt_dp.sv =====
// datapath: registers, path walk, traversal stacks and the node memory
module grmt_dp import grmt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_op_t                  op,
  output dp_status_t              status,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  side_t                   cfg_data,
  input  item_t                   in_item,
  output value_t                  max_value,
  output logic                    range_error
);
  side_t  rows_cfg, cols_cfg, n_use, m_use;
  item_t  it;
  addr_t  clr_addr;
  node_t  xp, yp, wx, wy;
  side_t  xlo, xhi, ylo, yhi;
  value_t opa, acc, wr_max;
  frame_t ofr, ifr;
  frame_t ostk [STACK_DEPTH];
  frame_t istk [STACK_DEPTH];
  logic [STACK_PTR_BITS-1:0] ocnt, icnt, odec, idec;
  logic [SIDE_BITS:0] xsum, ysum, osum, isum;
  side_t  xmid, ymid, omid, imid;
  logic   ram_we, bad;
  addr_t  waddr, raddr;
  value_t wdata, rdata;

  assign n_use = clamp_side(rows_cfg);
  assign m_use = clamp_side(cols_cfg);

  assign xsum = {1'b0, xlo} + {1'b0, xhi};
  assign ysum = {1'b0, ylo} + {1'b0, yhi};
  assign osum = {1'b0, ofr.lo} + {1'b0, ofr.hi};
  assign isum = {1'b0, ifr.lo} + {1'b0, ifr.hi};
  assign xmid = xsum[SIDE_BITS:1];
  assign ymid = ysum[SIDE_BITS:1];
  assign omid = osum[SIDE_BITS:1];
  assign imid = isum[SIDE_BITS:1];
  assign odec = ocnt - 1'b1;
  assign idec = icnt - 1'b1;

  assign bad = (it.row_low == '0) || (it.col_low == '0) || (it.row_low > it.row_high) ||
               (it.col_low > it.col_high) || (it.row_high > n_use) ||
               (it.col_high > m_use);

  assign status.clear_last  = &clr_addr;
  assign status.is_query    = (it.command == CMD_QUERY);
  assign status.write_ok    = (it.cell_row != '0) && (it.cell_row <= n_use) &&
                              (it.cell_col != '0) && (it.cell_col <= m_use);
  assign status.query_bad   = bad;
  assign status.path_done   = (xlo == xhi) && (ylo == yhi);
  assign status.write_last  = (wx == node_t'(1)) && (wy == node_t'(1));
  assign status.out_covered = (ofr.lo >= it.row_low) && (ofr.hi <= it.row_high);
  assign status.in_covered  = (ifr.lo >= it.col_low) && (ifr.hi <= it.col_high);
  assign status.out_empty   = (ocnt == '0);
  assign status.in_empty    = (icnt == '0);

  assign wr_max = vmax(opa, rdata);

  // memory port selection
  always_comb begin
    ram_we = 1'b0;
    waddr  = {wx, wy};
    wdata  = wr_max;
    raddr  = {ofr.node, ifr.node};
    unique case (op)
      OP_CLEAR: begin
        ram_we = 1'b1;
        waddr  = clr_addr;
        wdata  = '0;
      end
      OP_WR_RDA: begin
        raddr = (wy == yp) ? {wx[NODE_BITS-2:0], 1'b0, wy} : {wx, wy[NODE_BITS-2:0], 1'b0};
      end
      OP_WR_RDB: begin
        raddr = (wy == yp) ? {wx[NODE_BITS-2:0], 1'b1, wy} : {wx, wy[NODE_BITS-2:0], 1'b1};
      end
      OP_WR_WRITE: begin
        ram_we = 1'b1;
        if ((wy == yp) && (wx == xp)) wdata = it.cell_value;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= side_t'(MAX_SIDE);
      cols_cfg <= side_t'(MAX_SIDE);
      clr_addr <= '0;
      ocnt     <= '0;
      icnt     <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) rows_cfg <= cfg_data;
        if (cfg_index == REG_COLS) cols_cfg <= cfg_data;
      end
      unique case (op)
        OP_CLEAR: clr_addr <= clr_addr + 1'b1;
        OP_LOAD: begin
          it   <= in_item;
          xp   <= node_t'(1);
          yp   <= node_t'(1);
          xlo  <= side_t'(1);
          xhi  <= n_use;
          ylo  <= side_t'(1);
          yhi  <= m_use;
          ofr  <= '{node: node_t'(1), lo: side_t'(1), hi: n_use};
          ocnt <= '0;
          acc  <= {1'b1, {(VALUE_BITS-1){1'b0}}};
        end
        OP_PATH: begin
          // descend both trees towards the leaf of the cell
          if (xlo != xhi) begin
            if (it.cell_row <= xmid) begin
              xp <= {xp[NODE_BITS-2:0], 1'b0};
              xhi <= xmid;
            end else begin
              xp <= {xp[NODE_BITS-2:0], 1'b1};
              xlo <= xmid + 1'b1;
            end
          end
          if (ylo != yhi) begin
            if (it.cell_col <= ymid) begin
              yp <= {yp[NODE_BITS-2:0], 1'b0};
              yhi <= ymid;
            end else begin
              yp <= {yp[NODE_BITS-2:0], 1'b1};
              ylo <= ymid + 1'b1;
            end
          end
          wx <= xp;
          wy <= yp;
        end
        OP_WR_RDA: ;
        OP_WR_RDB: opa <= rdata;
        OP_WR_WRITE: begin
          // climb the column path, then the next row ancestor
          if (wy == node_t'(1)) begin
            wx <= wx >> 1;
            wy <= yp;
          end else begin
            wy <= wy >> 1;
          end
        end
        OP_OVISIT: begin
          if (status.out_covered) begin
            ifr  <= '{node: node_t'(1), lo: side_t'(1), hi: m_use};
            icnt <= '0;
          end else if (omid >= it.row_high) begin
            ofr <= '{node: {ofr.node[NODE_BITS-2:0], 1'b0}, lo: ofr.lo, hi: omid};
          end else if (omid < it.row_low) begin
            ofr <= '{node: {ofr.node[NODE_BITS-2:0], 1'b1}, lo: omid + 1'b1, hi: ofr.hi};
          end else begin
            ostk[ocnt[STACK_IDX_BITS-1:0]] <=
              '{node: {ofr.node[NODE_BITS-2:0], 1'b1}, lo: omid + 1'b1, hi: ofr.hi};
            ocnt <= ocnt + 1'b1;
            ofr  <= '{node: {ofr.node[NODE_BITS-2:0], 1'b0}, lo: ofr.lo, hi: omid};
          end
        end
        OP_IVISIT: begin
          if (status.in_covered) begin
            // node read goes out this cycle
          end else if (imid >= it.col_high) begin
            ifr <= '{node: {ifr.node[NODE_BITS-2:0], 1'b0}, lo: ifr.lo, hi: imid};
          end else if (imid < it.col_low) begin
            ifr <= '{node: {ifr.node[NODE_BITS-2:0], 1'b1}, lo: imid + 1'b1, hi: ifr.hi};
          end else begin
            istk[icnt[STACK_IDX_BITS-1:0]] <=
              '{node: {ifr.node[NODE_BITS-2:0], 1'b1}, lo: imid + 1'b1, hi: ifr.hi};
            icnt <= icnt + 1'b1;
            ifr  <= '{node: {ifr.node[NODE_BITS-2:0], 1'b0}, lo: ifr.lo, hi: imid};
          end
        end
        OP_IACC: begin
          acc <= vmax(acc, rdata);
          if (!status.in_empty) begin
            ifr  <= istk[idec[STACK_IDX_BITS-1:0]];
            icnt <= idec;
          end
        end
        OP_OPOP: begin
          if (!status.out_empty) begin
            ofr  <= ostk[odec[STACK_IDX_BITS-1:0]];
            ocnt <= odec;
          end
        end
        OP_EMIT: begin
          max_value   <= bad ? value_t'(0) : acc;
          range_error <= bad;
        end
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  grmt_ram #(.WIDTH(VALUE_BITS), .DEPTH(MEM_DEPTH)) u_nodes (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );
endmodule

// ===== rtl/grmt_ctrl.sv =====
// controller: sequences clearing, cell writes and rectangle queries
module grmt_ctrl import grmt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_op_t     op,
  input  dp_status_t status
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECIDE, S_PATH, S_WRA, S_WRB, S_WRW,
    S_OVISIT, S_IVISIT, S_IACC, S_OPOP, S_DONE
  } state_t;

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    op         = OP_NONE;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (status.is_query && status.query_bad) state_next = S_DONE;
        else if (status.is_query) state_next = S_OVISIT;
        else if (status.write_ok) state_next = S_PATH;
        else state_next = S_IDLE;
      end
      S_PATH: begin
        op = OP_PATH;
        if (status.path_done) state_next = S_WRA;
      end
      S_WRA: begin
        op         = OP_WR_RDA;
        state_next = S_WRB;
      end
      S_WRB: begin
        op         = OP_WR_RDB;
        state_next = S_WRW;
      end
      S_WRW: begin
        op         = OP_WR_WRITE;
        state_next = status.write_last ? S_IDLE : S_WRA;
      end
      S_OVISIT: begin
        op = OP_OVISIT;
        if (status.out_covered) state_next = S_IVISIT;
      end
      S_IVISIT: begin
        op = OP_IVISIT;
        if (status.in_covered) state_next = S_IACC;
      end
      S_IACC: begin
        op         = OP_IACC;
        state_next = status.in_empty ? S_OPOP : S_IVISIT;
      end
      S_OPOP: begin
        op         = OP_OPOP;
        state_next = status.out_empty ? S_DONE : S_OVISIT;
      end
      S_DONE: begin
        if (slot_free) begin
          op         = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (op == OP_EMIT) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_acc_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_IACC) |-> ($past(state) == S_IVISIT))
    else $error("accumulate without a node read");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT) |=> out_valid)
    else $error("result not presented after emit");

  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (op == OP_EMIT) |-> slot_free)
    else $error("result overwritten before it was taken");

endmodule

// ===== rtl/grid_range_max_tree_top.sv =====
// top level of the two-dimensional range maximum tree
// After reset the node memory is swept to zero, one node a cycle, all 262144 nodes, and no
// command word is taken until that pass ends (register writes are taken throughout). Commands
// are handled one at a time through a single node memory: a cell write walks to its leaf
// down both trees and then rewrites every node of the row path crossed with the column path,
// reading two child nodes before each node above the leaf is written. A query visits row tree
// nodes, searches the column tree of each covered row node and reads each covered column node
// into the running maximum. A finished answer waits in the output register while the next
// command is taken.
module grid_range_max_tree_top import grmt_pkg::*; (
  input logic   clk,
  input logic   rst,
  grmt_in_if.sink    items,
  grmt_out_if.source results,
  grmt_cfg_if.sink   cfg
);
  dp_op_t     op;
  dp_status_t status;
  item_t      in_item;

  assign cfg.ready = 1'b1;

  assign in_item = '{command: items.command, cell_row: items.cell_row,
                     cell_col: items.cell_col, cell_value: items.cell_value,
                     row_low: items.row_low, col_low: items.col_low,
                     row_high: items.row_high, col_high: items.col_high};

  grmt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .op        (op),
    .status    (status)
  );

  grmt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .op          (op),
    .status      (status),
    .cfg_we      (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .in_item     (in_item),
    .max_value   (results.max_value),
    .range_error (results.range_error)
  );
endmodule
